// ===== src/wrsi_pkg.sv =====
package wrsi_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int FRAC_BITS = 16;
   localparam int PERIOD_W  = 10;
   localparam int SUM_W     = 42;
   localparam int AVG_W     = 48;
   localparam int RSI_W     = 23;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;

   // divider datapath
   localparam int DEN_W   = AVG_W + 1;
   localparam int STEP_W  = 6;
   localparam int SCALE_W = 7;
   localparam int RATIO_STEPS = SCALE_W + FRAC_BITS;
   localparam int T_W     = AVG_W + PERIOD_W + 1;

   localparam logic [SCALE_W-1:0]  RSI_SCALE = SCALE_W'(100);
   localparam logic [RSI_W-1:0]    RSI_FULL  = RSI_W'(100 * (2 ** FRAC_BITS));
   localparam logic [STEP_W-1:0]   AVG_STEPS = STEP_W'(AVG_W);
   localparam logic [STEP_W-1:0]   RSI_STEPS = STEP_W'(RATIO_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_LEVEL  = 2'd2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 10'd14;
   localparam logic [SAMPLE_W-1:0] SWAP_LEVEL_RESET = 32'd65536;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_WARM,
      CMD_SMOOTH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [SUM_W-1:0]    gain;
      logic [SUM_W-1:0]    loss;
      logic [PERIOD_W-1:0] period;
   } cmd_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                swap_enable;
      logic [SAMPLE_W-1:0] swap_level;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DEN_W-1:0]   rem;
      logic [AVG_W-1:0]   dividend;
      logic [DEN_W-1:0]   divisor;
      logic [STEP_W-1:0]  steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [AVG_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== src/wrsi_if.sv =====
interface wrsi_req_if;
   logic                         valid;
   logic                         ready;
   logic [wrsi_pkg::SAMPLE_W-1:0] sample;
   logic                         first;

   modport source (output valid, output sample, output first, input ready);
   modport sink   (input valid, input sample, input first, output ready);
endinterface

interface wrsi_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [wrsi_pkg::RSI_W-1:0] rsi;
   logic                      undefined;

   modport source (output valid, output rsi, output undefined, input ready);
   modport sink   (input valid, input rsi, input undefined, output ready);
endinterface

// ===== src/wrsi_front.sv =====
module wrsi_front (
   input  logic              clock,
   input  logic              reset,
   wrsi_req_if.sink          req,
   input  wrsi_pkg::cfg_type cfg,
   input  logic              full,
   output logic              push,
   output wrsi_pkg::cmd_type cmd
);

   logic [wrsi_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic                          have_ff, have_in;
   logic [wrsi_pkg::PERIOD_W:0]   cnt_ff, cnt_in;
   logic [wrsi_pkg::SUM_W-1:0]    gsum_ff, gsum_in, lsum_ff, lsum_in;

   logic [wrsi_pkg::SAMPLE_W-1:0] s, d, g_in, l_in;
   logic                          rise, swapped, gain, start, accept;
   logic [wrsi_pkg::PERIOD_W-1:0] p;
   logic [wrsi_pkg::PERIOD_W:0]   p_ext, p1, k_raw, k;
   logic [wrsi_pkg::SUM_W-1:0]    gsum_next, lsum_next;

   function automatic logic [wrsi_pkg::SUM_W-1:0] sat_add(
      input logic [wrsi_pkg::SUM_W-1:0]    a,
      input logic [wrsi_pkg::SAMPLE_W-1:0] b
   );
      logic [wrsi_pkg::SUM_W:0] t;
      t = {1'b0, a} + (wrsi_pkg::SUM_W + 1)'(b);
      return t[wrsi_pkg::SUM_W] ? {wrsi_pkg::SUM_W{1'b1}} : t[wrsi_pkg::SUM_W-1:0];
   endfunction

   assign req.ready = !full;
   assign accept    = req.valid && !full;

   always_comb begin
      s       = req.sample;
      rise    = s > prev_ff;
      swapped = cfg.swap_enable && !(s < cfg.swap_level && prev_ff < cfg.swap_level);
      gain    = rise ^ swapped;
      d       = rise ? s - prev_ff : prev_ff - s;
      g_in    = gain ? d : '0;
      l_in    = gain ? '0 : d;
      start   = req.first || !have_ff;

      p     = (cfg.period == '0) ? wrsi_pkg::PERIOD_W'(1) : cfg.period;
      p_ext = {1'b0, p};
      p1    = p_ext + 1'b1;
      k_raw = cnt_ff + 1'b1;
      k     = (k_raw > p1) ? p1 : k_raw;

      gsum_next = sat_add(gsum_ff, g_in);
      lsum_next = sat_add(lsum_ff, l_in);

      push       = accept && (start || k >= p_ext);
      cmd.period = p;
      if (start) begin
         cmd.kind = wrsi_pkg::CMD_CLEAR;
         cmd.gain = '0;
         cmd.loss = '0;
      end else if (k == p_ext) begin
         cmd.kind = wrsi_pkg::CMD_WARM;
         cmd.gain = gsum_next;
         cmd.loss = lsum_next;
      end else begin
         cmd.kind = wrsi_pkg::CMD_SMOOTH;
         cmd.gain = wrsi_pkg::SUM_W'(g_in);
         cmd.loss = wrsi_pkg::SUM_W'(l_in);
      end

      prev_in = prev_ff;
      have_in = have_ff;
      cnt_in  = cnt_ff;
      gsum_in = gsum_ff;
      lsum_in = lsum_ff;
      if (accept) begin
         prev_in = s;
         have_in = 1'b1;
         if (start) begin
            cnt_in  = '0;
            gsum_in = '0;
            lsum_in = '0;
         end else begin
            cnt_in = k;
            if (k < p_ext) begin
               gsum_in = gsum_next;
               lsum_in = lsum_next;
            end else if (k == p_ext) begin
               gsum_in = '0;
               lsum_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         have_ff <= 1'b0;
         cnt_ff  <= '0;
         gsum_ff <= '0;
         lsum_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         have_ff <= have_in;
         cnt_ff  <= cnt_in;
         gsum_ff <= gsum_in;
         lsum_ff <= lsum_in;
      end
   end

endmodule

// ===== src/wrsi_fifo.sv =====
module wrsi_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wrsi_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output wrsi_pkg::cmd_type head_cmd
);

   wrsi_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/wrsi_div.sv =====
module wrsi_div (
   input  logic                  clock,
   input  logic                  reset,
   input  wrsi_pkg::div_req_type req,
   output wrsi_pkg::div_rsp_type rsp
);

   logic                          busy_ff, done_ff;
   logic [wrsi_pkg::STEP_W-1:0]   cnt_ff;
   logic [wrsi_pkg::DEN_W-1:0]    rem_ff, rem_in, div_ff;
   logic [wrsi_pkg::AVG_W-1:0]    dvd_ff, q_ff, q_in;
   logic [wrsi_pkg::DEN_W:0]      trial, diff;
   logic                          ge;

   always_comb begin
      trial  = {rem_ff, dvd_ff[wrsi_pkg::AVG_W-1]};
      diff   = trial - {1'b0, div_ff};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? diff[wrsi_pkg::DEN_W-1:0] : trial[wrsi_pkg::DEN_W-1:0];
      q_in   = {q_ff[wrsi_pkg::AVG_W-2:0], ge};
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.rem;
         dvd_ff <= req.dividend;
         div_ff <= req.divisor;
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[wrsi_pkg::AVG_W-2:0], 1'b0};
         q_ff   <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == wrsi_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== src/wrsi_back.sv =====
module wrsi_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  wrsi_pkg::cmd_type head_cmd,
   output logic              pop,
   wrsi_rsp_if.source        rsp
);

   typedef enum logic [3:0] {
      S_IDLE, S_GO_WG, S_DIV_WG, S_GO_WL, S_DIV_WL,
      S_MUL_G, S_GO_G, S_DIV_G, S_MUL_L, S_GO_L, S_DIV_L,
      S_EVAL, S_GO_R, S_DIV_R, S_OUT
   } state_type;

   state_type                      state_ff;
   wrsi_pkg::cmd_type              cmd_ff;
   logic [wrsi_pkg::AVG_W-1:0]     avg_g_ff, avg_l_ff;
   logic [wrsi_pkg::T_W-1:0]       t_ff, t_in;
   logic [wrsi_pkg::RSI_W-1:0]     res_rsi_ff, rsi_ff;
   logic                           res_undef_ff, undef_ff, rsp_valid_ff;

   wrsi_pkg::div_req_type          dreq;
   wrsi_pkg::div_rsp_type          drsp;
   logic [wrsi_pkg::AVG_W-1:0]     mul_avg;
   logic [wrsi_pkg::SUM_W-1:0]     mul_d;
   logic [wrsi_pkg::PERIOD_W-1:0]  m;
   logic [wrsi_pkg::AVG_W+wrsi_pkg::PERIOD_W-1:0] mul_prod;
   logic [wrsi_pkg::AVG_W+wrsi_pkg::SCALE_W-1:0] prod;
   logic                           out_free;

   wrsi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign pop       = (state_ff == S_IDLE) && head_valid;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.rsi   = rsi_ff;
   assign rsp.undefined = undef_ff;

   // shared multiplier: avg * (p - 1) + d, gain first then loss
   always_comb begin
      m        = cmd_ff.period - 1'b1;
      mul_avg  = (state_ff == S_MUL_L) ? avg_l_ff : avg_g_ff;
      mul_d    = (state_ff == S_MUL_L) ? cmd_ff.loss : cmd_ff.gain;
      mul_prod = mul_avg * m;
      t_in     = wrsi_pkg::T_W'(mul_prod) + wrsi_pkg::T_W'(mul_d);
      prod     = avg_g_ff * wrsi_pkg::RSI_SCALE;
   end

   always_comb begin
      dreq.start    = 1'b0;
      dreq.rem      = wrsi_pkg::DEN_W'(t_ff >> wrsi_pkg::AVG_W);
      dreq.dividend = t_ff[wrsi_pkg::AVG_W-1:0];
      dreq.divisor  = wrsi_pkg::DEN_W'(cmd_ff.period);
      dreq.steps    = wrsi_pkg::AVG_STEPS;
      case (state_ff)
         S_GO_WG: begin
            dreq.start    = 1'b1;
            dreq.rem      = '0;
            dreq.dividend = wrsi_pkg::AVG_W'(cmd_ff.gain);
         end
         S_GO_WL: begin
            dreq.start    = 1'b1;
            dreq.rem      = '0;
            dreq.dividend = wrsi_pkg::AVG_W'(cmd_ff.loss);
         end
         S_GO_G, S_GO_L: begin
            dreq.start = 1'b1;
         end
         S_GO_R: begin
            // 100 * g << frac over (g + l), quotient below 2^RATIO_STEPS
            dreq.start    = 1'b1;
            dreq.rem      = wrsi_pkg::DEN_W'(prod >> wrsi_pkg::SCALE_W);
            dreq.dividend = {prod[wrsi_pkg::SCALE_W-1:0],
                             {(wrsi_pkg::AVG_W-wrsi_pkg::SCALE_W){1'b0}}};
            dreq.divisor  = {1'b0, avg_g_ff} + {1'b0, avg_l_ff};
            dreq.steps    = wrsi_pkg::RSI_STEPS;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL_G || state_ff == S_MUL_L) begin
         t_ff <= t_in;
      end
      if (pop) begin
         cmd_ff <= head_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         avg_g_ff     <= '0;
         avg_l_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         res_rsi_ff   <= '0;
         res_undef_ff <= 1'b0;
         rsi_ff       <= '0;
         undef_ff     <= 1'b0;
      end else begin
         // raise valid as the staged word moves out, drop it once taken
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (head_valid) begin
                  case (head_cmd.kind)
                     wrsi_pkg::CMD_CLEAR: begin
                        avg_g_ff <= '0;
                        avg_l_ff <= '0;
                     end
                     wrsi_pkg::CMD_WARM:   state_ff <= S_GO_WG;
                     wrsi_pkg::CMD_SMOOTH: state_ff <= S_MUL_G;
                     default: begin
                     end
                  endcase
               end
            end
            S_GO_WG:  state_ff <= S_DIV_WG;
            S_DIV_WG: if (drsp.done) begin
               avg_g_ff <= drsp.quotient;
               state_ff <= S_GO_WL;
            end
            S_GO_WL:  state_ff <= S_DIV_WL;
            S_DIV_WL: if (drsp.done) begin
               avg_l_ff <= drsp.quotient;
               state_ff <= S_IDLE;
            end
            S_MUL_G:  state_ff <= S_GO_G;
            S_GO_G:   state_ff <= S_DIV_G;
            S_DIV_G:  if (drsp.done) begin
               avg_g_ff <= drsp.quotient;
               state_ff <= S_MUL_L;
            end
            S_MUL_L:  state_ff <= S_GO_L;
            S_GO_L:   state_ff <= S_DIV_L;
            S_DIV_L:  if (drsp.done) begin
               avg_l_ff <= drsp.quotient;
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if (avg_l_ff == '0) begin
                  res_undef_ff <= avg_g_ff == '0;
                  res_rsi_ff   <= (avg_g_ff == '0) ? '0 : wrsi_pkg::RSI_FULL;
                  state_ff     <= S_OUT;
               end else begin
                  state_ff <= S_GO_R;
               end
            end
            S_GO_R:   state_ff <= S_DIV_R;
            S_DIV_R:  if (drsp.done) begin
               res_rsi_ff   <= drsp.quotient[wrsi_pkg::RSI_W-1:0];
               res_undef_ff <= 1'b0;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsi_ff       <= res_rsi_ff;
                  undef_ff     <= res_undef_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_ratio_needs_loss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GO_R) |-> (avg_l_ff != '0))
      else $error("ratio division started with zero loss average");
   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> (state_ff == S_DIV_WG || state_ff == S_DIV_WL ||
                     state_ff == S_DIV_G || state_ff == S_DIV_L || state_ff == S_DIV_R))
      else $error("divider finished outside a wait state");
   a_rsi_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsi_ff <= wrsi_pkg::RSI_FULL))
      else $error("rsi word above full scale");
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && undef_ff) |-> (rsi_ff == '0))
      else $error("undefined word carries nonzero rsi");
`endif

endmodule

// ===== src/wilder_rsi_indicator.sv =====
// Relative strength index with Wilder smoothing.
//
// req_port carries one word per sample: an unsigned Q16.16 sample and a
// first flag that starts a new series. rsp_port carries the RSI in Q7.16
// plus an undefined flag; both are valid/ready channels. Registers are
// written through csr_write_enable / csr_index / csr_write_data:
// 0 period, 1 swap enable, 2 swap level; write them only while idle.
//
// The front accepts a word whenever the queue is not full, classifies the
// difference and keeps the warm-up sums; a two-entry command queue feeds
// the back, which owns the averages and one shared restoring divider
// retiring one quotient bit a cycle. A smoothing word runs two average
// divisions (48 divider steps each) plus, unless the loss average is zero,
// a ratio division (23 steps); the end of warm-up runs two 48-step
// divisions, a series start none. The divider sets the sustained rate.
//
// Reset is synchronous; no clearing pass. A stalled receiver holds the
// output register; the back finishes the next word into a staging register
// and the queue keeps taking words until it fills.
module wilder_rsi_indicator (
   input  logic                           clock,
   input  logic                           reset,
   wrsi_req_if.sink                       req_port,
   wrsi_rsp_if.source                     rsp_port,
   input  logic                           csr_write_enable,
   input  logic [wrsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wrsi_pkg::CSR_W-1:0]     csr_write_data
);

   wrsi_pkg::cfg_type cfg_ff;
   wrsi_pkg::cmd_type push_cmd, head_cmd;
   logic              push, full, pop, head_valid;

   // hold the register file; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period      <= wrsi_pkg::PERIOD_RESET;
         cfg_ff.swap_enable <= 1'b1;
         cfg_ff.swap_level  <= wrsi_pkg::SWAP_LEVEL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            wrsi_pkg::CSR_PERIOD:
               cfg_ff.period <= csr_write_data[wrsi_pkg::PERIOD_W-1:0];
            wrsi_pkg::CSR_SWAP_ENABLE:
               cfg_ff.swap_enable <= csr_write_data[0];
            wrsi_pkg::CSR_SWAP_LEVEL:
               cfg_ff.swap_level <= csr_write_data[wrsi_pkg::SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   wrsi_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_port),
      .cfg   (cfg_ff),
      .full  (full),
      .push  (push),
      .cmd   (push_cmd)
   );

   wrsi_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   wrsi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp_port)
   );

endmodule
